### rtl/touch_dpad_sector_classifier_defines.svh
// assertion macros for the touch d-pad sector classifier
// expects signals named clk and rst_n in the module that uses them
`ifndef TOUCH_DPAD_SECTOR_CLASSIFIER_DEFINES_SVH
`define TOUCH_DPAD_SECTOR_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TDSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdsc assertion failed");
// next-cycle implication
`define TDSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdsc assertion failed");
`else
`define TDSC_ASSERT_NOW(label, ante, cons)
`define TDSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/tdsc_pkg.sv
// shared types, codes and constants of the touch d-pad sector classifier
// no dependencies
`timescale 1ns / 1ps

package tdsc_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int FINGER_BITS_DEF   = 4;
    localparam int TAN_FRAC_BITS_DEF = 16;

    localparam int CFG_ADDR_BITS = 3;
    localparam int STATE_BITS    = 2;
    localparam int BTN_BITS      = 4;
    localparam int OUT_DATA_BITS = 8;

    // tan(pi/8) and 1/tan(pi/8) in Q32, rounded
    localparam logic [63:0] TAN_Q32 = 64'd1779033704;
    localparam logic [63:0] COT_Q32 = 64'd10368968296;

    localparam logic [BTN_BITS-1:0] BTN_NONE  = 4'b0000;
    localparam logic [BTN_BITS-1:0] BTN_UP    = 4'b0001;
    localparam logic [BTN_BITS-1:0] BTN_DOWN  = 4'b0010;
    localparam logic [BTN_BITS-1:0] BTN_LEFT  = 4'b0100;
    localparam logic [BTN_BITS-1:0] BTN_RIGHT = 4'b1000;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_RADIUS      = 3'd2,
        CFG_DEAD_ZONE   = 3'd3,
        CFG_SECTOR_MODE = 3'd4,
        CFG_FLIP_X      = 3'd5,
        CFG_FLIP_Y      = 3'd6
    } cfg_index_t;

    typedef enum logic [STATE_BITS-1:0] {
        TS_OFF    = 2'd0,
        TS_DEAD   = 2'd1,
        TS_ACTIVE = 2'd2
    } touch_state_t;

    typedef struct packed {
        logic sector_mode;
        logic flip_x;
        logic flip_y;
    } cfg_mode_t;

    // round a Q32 constant to frac_bits fraction bits
    function automatic logic [63:0] q32_to_frac(input logic [63:0] q32, input int frac_bits);
        return (q32 + (64'd1 << (31 - frac_bits))) >> (32 - frac_bits);
    endfunction

endpackage

### rtl/tdsc_cfg.sv
// configuration register file; squares the radius and dead zone on write
// depends on tdsc_pkg
`timescale 1ns / 1ps

module tdsc_cfg
    import tdsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [COORD_BITS-1:0]     cfg_wdata,
    output logic [COORD_BITS-1:0]     center_x,
    output logic [COORD_BITS-1:0]     center_y,
    output logic [2*COORD_BITS-1:0]   radius_sq,
    output logic [2*COORD_BITS-1:0]   dead_sq,
    output cfg_mode_t                 mode
);

    localparam int SQ_BITS = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] center_x_reg;
    logic [COORD_BITS-1:0] center_y_reg;
    logic [SQ_BITS-1:0]    radius_sq_reg;
    logic [SQ_BITS-1:0]    dead_sq_reg;
    cfg_mode_t             mode_reg;
    logic [SQ_BITS-1:0]    wdata_sq;

    assign wdata_sq = SQ_BITS'(cfg_wdata) * SQ_BITS'(cfg_wdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_sq_reg <= '0;
            dead_sq_reg   <= '0;
            mode_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_CENTER_X:    center_x_reg         <= cfg_wdata;
                CFG_CENTER_Y:    center_y_reg         <= cfg_wdata;
                CFG_RADIUS:      radius_sq_reg        <= wdata_sq;
                CFG_DEAD_ZONE:   dead_sq_reg          <= wdata_sq;
                CFG_SECTOR_MODE: mode_reg.sector_mode <= cfg_wdata[0];
                CFG_FLIP_X:      mode_reg.flip_x      <= cfg_wdata[0];
                CFG_FLIP_Y:      mode_reg.flip_y      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign center_x  = center_x_reg;
    assign center_y  = center_y_reg;
    assign radius_sq = radius_sq_reg;
    assign dead_sq   = dead_sq_reg;
    assign mode      = mode_reg;

endmodule

### rtl/tdsc_geom.sv
// geometry stage: offsets from the centre, squares and sector-line products
// depends on tdsc_pkg
`timescale 1ns / 1ps

module tdsc_geom
    import tdsc_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FINGER_BITS   = FINGER_BITS_DEF,
    parameter int TAN_FRAC_BITS = TAN_FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [FINGER_BITS-1:0]                   in_finger,
    input  logic [COORD_BITS-1:0]                    in_x,
    input  logic [COORD_BITS-1:0]                    in_y,
    input  logic [COORD_BITS-1:0]                    center_x,
    input  logic [COORD_BITS-1:0]                    center_y,
    input  cfg_mode_t                                mode,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [FINGER_BITS-1:0]                   out_finger,
    output logic [2*COORD_BITS-1:0]                  sq_x,
    output logic [2*COORD_BITS-1:0]                  sq_y,
    output logic signed [COORD_BITS:0]               sx,
    output logic signed [COORD_BITS:0]               sy,
    output logic signed [COORD_BITS+TAN_FRAC_BITS+2:0] prod_tan,
    output logic signed [COORD_BITS+TAN_FRAC_BITS+2:0] prod_cot
);

    localparam int SQ_BITS = 2 * COORD_BITS;
    localparam int K_BITS  = TAN_FRAC_BITS + 2;
    localparam int P_BITS  = COORD_BITS + TAN_FRAC_BITS + 3;

    localparam logic [63:0] K_TAN_FULL = q32_to_frac(TAN_Q32, TAN_FRAC_BITS);
    localparam logic [63:0] K_COT_FULL = q32_to_frac(COT_Q32, TAN_FRAC_BITS);
    localparam logic signed [P_BITS-1:0] K_TAN = P_BITS'(K_TAN_FULL[K_BITS-1:0]);
    localparam logic signed [P_BITS-1:0] K_COT = P_BITS'(K_COT_FULL[K_BITS-1:0]);

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0]        adx;
    logic [COORD_BITS-1:0]        ady;
    logic signed [COORD_BITS:0]   fx;
    logic signed [COORD_BITS:0]   fy;
    logic signed [P_BITS-1:0]     fx_ext;
    logic                         load;

    logic                         valid_reg;
    logic [FINGER_BITS-1:0]       finger_reg;
    logic [SQ_BITS-1:0]           sq_x_reg;
    logic [SQ_BITS-1:0]           sq_y_reg;
    logic signed [COORD_BITS:0]   sx_reg;
    logic signed [COORD_BITS:0]   sy_reg;
    logic signed [P_BITS-1:0]     prod_tan_reg;
    logic signed [P_BITS-1:0]     prod_cot_reg;

    assign dx = $signed({1'b0, in_x}) - $signed({1'b0, center_x});
    assign dy = $signed({1'b0, in_y}) - $signed({1'b0, center_y});

    // magnitude always fits in COORD_BITS
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

    assign fx     = mode.flip_x ? -dx : dx;
    assign fy     = mode.flip_y ? -dy : dy;
    assign fx_ext = P_BITS'(fx);

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            finger_reg   <= in_finger;
            sq_x_reg     <= SQ_BITS'(adx) * SQ_BITS'(adx);
            sq_y_reg     <= SQ_BITS'(ady) * SQ_BITS'(ady);
            sx_reg       <= fx;
            sy_reg       <= fy;
            prod_tan_reg <= fx_ext * K_TAN;
            prod_cot_reg <= fx_ext * K_COT;
        end
    end

    assign out_valid  = valid_reg;
    assign out_finger = finger_reg;
    assign sq_x       = sq_x_reg;
    assign sq_y       = sq_y_reg;
    assign sx         = sx_reg;
    assign sy         = sy_reg;
    assign prod_tan   = prod_tan_reg;
    assign prod_cot   = prod_cot_reg;

endmodule

### rtl/tdsc_decide.sv
// decision stage: pad ownership, radius and dead-zone tests, sector buttons
// depends on tdsc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "touch_dpad_sector_classifier_defines.svh"

module tdsc_decide
    import tdsc_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FINGER_BITS   = FINGER_BITS_DEF,
    parameter int TAN_FRAC_BITS = TAN_FRAC_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [FINGER_BITS-1:0]                     in_finger,
    input  logic [2*COORD_BITS-1:0]                    sq_x,
    input  logic [2*COORD_BITS-1:0]                    sq_y,
    input  logic signed [COORD_BITS:0]                 sx,
    input  logic signed [COORD_BITS:0]                 sy,
    input  logic signed [COORD_BITS+TAN_FRAC_BITS+2:0] prod_tan,
    input  logic signed [COORD_BITS+TAN_FRAC_BITS+2:0] prod_cot,
    input  logic [2*COORD_BITS-1:0]                    radius_sq,
    input  logic [2*COORD_BITS-1:0]                    dead_sq,
    input  cfg_mode_t                                  mode,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [STATE_BITS-1:0]                      touch_state,
    output logic [BTN_BITS-1:0]                        buttons
);

    localparam int SQ_BITS = 2 * COORD_BITS;
    localparam int P_BITS  = COORD_BITS + TAN_FRAC_BITS + 3;

    logic                        out_valid_reg;
    touch_state_t                state_reg;
    touch_state_t                state_next;
    logic                        owner_valid_reg;
    logic                        owner_valid_next;
    logic [FINGER_BITS-1:0]      owner_finger_reg;
    logic [FINGER_BITS-1:0]      owner_finger_next;
    logic [BTN_BITS-1:0]         last_buttons_reg;
    logic [BTN_BITS-1:0]         last_buttons_next;

    logic                        load;
    logic                        other_finger;
    logic [SQ_BITS:0]            dist_sq;
    logic                        outside;
    logic                        in_dead;
    logic signed [P_BITS-1:0]    yq;
    logic signed [P_BITS:0]      sum_tan;
    logic signed [P_BITS:0]      sum_cot;
    logic signed [COORD_BITS+1:0] sum_xy;
    logic [3:0]                  pat8;
    logic [1:0]                  pat4;
    logic [BTN_BITS-1:0]         sector_btn;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign other_finger = owner_valid_reg && (owner_finger_reg != in_finger);

    assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
    assign outside = dist_sq > {1'b0, radius_sq};
    assign in_dead = dist_sq < {1'b0, dead_sq};

    // y scaled to the tangent fixed point
    assign yq      = P_BITS'(sy) <<< TAN_FRAC_BITS;
    assign sum_tan = (P_BITS + 1)'(yq) + (P_BITS + 1)'(prod_tan);
    assign sum_cot = (P_BITS + 1)'(yq) + (P_BITS + 1)'(prod_cot);
    assign sum_xy  = (COORD_BITS + 2)'(sx) + (COORD_BITS + 2)'(sy);

    // eight sectors: above the mirrored and direct 22.5 / 67.5 degree lines
    assign pat8[0] = !sum_cot[P_BITS] && (sum_cot != '0);
    assign pat8[1] = !sum_tan[P_BITS] && (sum_tan != '0);
    assign pat8[2] = yq > prod_tan;
    assign pat8[3] = yq > prod_cot;

    // four sectors: the two diagonals
    assign pat4[0] = !sum_xy[COORD_BITS+1] && (sum_xy != '0);
    assign pat4[1] = sy > sx;

    always_comb
    begin
        sector_btn = BTN_NONE;
        if (mode.sector_mode)
        begin
            case (pat8)
                4'd0:    sector_btn = BTN_DOWN;
                4'd1:    sector_btn = BTN_DOWN | BTN_RIGHT;
                4'd3:    sector_btn = BTN_RIGHT;
                4'd7:    sector_btn = BTN_UP | BTN_RIGHT;
                4'd15:   sector_btn = BTN_UP;
                4'd14:   sector_btn = BTN_UP | BTN_LEFT;
                4'd12:   sector_btn = BTN_LEFT;
                4'd8:    sector_btn = BTN_DOWN | BTN_LEFT;
                default: sector_btn = BTN_NONE;
            endcase
        end
        else
        begin
            case (pat4)
                2'd0:    sector_btn = BTN_DOWN;
                2'd1:    sector_btn = BTN_RIGHT;
                2'd3:    sector_btn = BTN_UP;
                default: sector_btn = BTN_LEFT;
            endcase
        end
    end

    always_comb
    begin
        state_next        = TS_OFF;
        owner_valid_next  = owner_valid_reg;
        owner_finger_next = owner_finger_reg;
        last_buttons_next = last_buttons_reg;
        if (!other_finger)
        begin
            last_buttons_next = BTN_NONE;
            if (outside)
            begin
                owner_valid_next = 1'b0;
            end
            else
            begin
                owner_valid_next  = 1'b1;
                owner_finger_next = in_finger;
                if (in_dead)
                begin
                    state_next = TS_DEAD;
                end
                else
                begin
                    state_next        = TS_ACTIVE;
                    last_buttons_next = sector_btn;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            owner_valid_reg  <= 1'b0;
            owner_finger_reg <= '0;
            last_buttons_reg <= BTN_NONE;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (load)
            begin
                owner_valid_reg  <= owner_valid_next;
                owner_finger_reg <= owner_finger_next;
                last_buttons_reg <= last_buttons_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            state_reg <= state_next;
        end
    end

    // the button field always mirrors the held button state
    assign out_valid   = out_valid_reg;
    assign touch_state = state_reg;
    assign buttons     = last_buttons_reg;

    `TDSC_ASSERT_NOW(a_dead_no_buttons, out_valid_reg && (state_reg == TS_DEAD), last_buttons_reg == BTN_NONE)
    `TDSC_ASSERT_NEXT(a_leave_clears_owner, load && !other_finger && outside, !owner_valid_reg)
    `TDSC_ASSERT_NEXT(a_reject_keeps_owner, load && other_finger, owner_valid_reg && (owner_finger_reg == $past(owner_finger_reg)))
    `TDSC_ASSERT_NOW(a_owner_only_on_item, $rose(owner_valid_reg), $past(load))

endmodule

### rtl/touch_dpad_sector_classifier.sv
// Touch d-pad sector classifier. Each item is one touch report (finger index,
// X, Y); each report yields exactly one result item (touch_state, buttons).
// The first finger landing inside the pad radius owns the pad; reports from
// any other finger get touch_state 0 and repeat the held buttons until the
// owner moves outside the radius. Inside the dead zone the state is 1 with no
// buttons, otherwise 2 with up/down/left/right bits from a 4- or 8-sector
// split (8-sector lines at 22.5 degrees with tangent constants rounded to
// TAN_FRAC_BITS fraction bits). One item is accepted per clock while the
// output is not stalled by m_tready; an item passes three registers: input
// register, geometry stage (offsets, squares, sector-line products),
// decision stage with the ownership register, which updates once per item
// in arrival order. Configuration must be written only while no item is in
// flight; the block itself does not enforce this.
// depends on tdsc_pkg, tdsc_cfg, tdsc_geom, tdsc_decide
`timescale 1ns / 1ps

module touch_dpad_sector_classifier
    import tdsc_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FINGER_BITS   = FINGER_BITS_DEF,
    parameter int TAN_FRAC_BITS = TAN_FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // configuration write port
    input  logic                                        cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]                    cfg_addr,
    input  logic [COORD_BITS-1:0]                       cfg_wdata,
    // touch reports
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // finger_index, touch_x, touch_y from bit 0 up, zero padded to bytes
    input  logic [((FINGER_BITS+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // classification results
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // touch_state (2), buttons (4) from bit 0 up, two zero bits on top
    output logic [OUT_DATA_BITS-1:0]                    m_tdata
);

    localparam int SQ_BITS = 2 * COORD_BITS;
    localparam int P_BITS  = COORD_BITS + TAN_FRAC_BITS + 3;

    // config
    logic [COORD_BITS-1:0]      center_x;
    logic [COORD_BITS-1:0]      center_y;
    logic [SQ_BITS-1:0]         radius_sq;
    logic [SQ_BITS-1:0]         dead_sq;
    cfg_mode_t                  mode;

    // input register
    logic                       in_valid_reg;
    logic [FINGER_BITS-1:0]     in_finger_reg;
    logic [COORD_BITS-1:0]      in_x_reg;
    logic [COORD_BITS-1:0]      in_y_reg;
    logic                       geom_ready;
    logic                       in_load;

    // geometry -> decision
    logic                       g_valid;
    logic                       dec_ready;
    logic [FINGER_BITS-1:0]     g_finger;
    logic [SQ_BITS-1:0]         g_sq_x;
    logic [SQ_BITS-1:0]         g_sq_y;
    logic signed [COORD_BITS:0] g_sx;
    logic signed [COORD_BITS:0] g_sy;
    logic signed [P_BITS-1:0]   g_prod_tan;
    logic signed [P_BITS-1:0]   g_prod_cot;

    logic [STATE_BITS-1:0]      res_state;
    logic [BTN_BITS-1:0]        res_buttons;

    tdsc_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius_sq (radius_sq),
        .dead_sq   (dead_sq),
        .mode      (mode)
    );

    // input register: frees the port while later stages are busy
    assign s_tready = !in_valid_reg || geom_ready;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_finger_reg <= s_tdata[FINGER_BITS-1:0];
            in_x_reg      <= s_tdata[FINGER_BITS+COORD_BITS-1:FINGER_BITS];
            in_y_reg      <= s_tdata[FINGER_BITS+2*COORD_BITS-1:FINGER_BITS+COORD_BITS];
        end
    end

    tdsc_geom #(
        .COORD_BITS    (COORD_BITS),
        .FINGER_BITS   (FINGER_BITS),
        .TAN_FRAC_BITS (TAN_FRAC_BITS)
    ) u_geom (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid_reg),
        .in_ready   (geom_ready),
        .in_finger  (in_finger_reg),
        .in_x       (in_x_reg),
        .in_y       (in_y_reg),
        .center_x   (center_x),
        .center_y   (center_y),
        .mode       (mode),
        .out_valid  (g_valid),
        .out_ready  (dec_ready),
        .out_finger (g_finger),
        .sq_x       (g_sq_x),
        .sq_y       (g_sq_y),
        .sx         (g_sx),
        .sy         (g_sy),
        .prod_tan   (g_prod_tan),
        .prod_cot   (g_prod_cot)
    );

    tdsc_decide #(
        .COORD_BITS    (COORD_BITS),
        .FINGER_BITS   (FINGER_BITS),
        .TAN_FRAC_BITS (TAN_FRAC_BITS)
    ) u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (g_valid),
        .in_ready    (dec_ready),
        .in_finger   (g_finger),
        .sq_x        (g_sq_x),
        .sq_y        (g_sq_y),
        .sx          (g_sx),
        .sy          (g_sy),
        .prod_tan    (g_prod_tan),
        .prod_cot    (g_prod_cot),
        .radius_sq   (radius_sq),
        .dead_sq     (dead_sq),
        .mode        (mode),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .touch_state (res_state),
        .buttons     (res_buttons)
    );

    assign m_tdata = {2'b00, res_buttons, res_state};

endmodule

### bench/tdsc_checker.sv
// result checker for the touch d-pad sector classifier bench
// predicts each report from its own copy of the pad setup and ownership
// depends on tdsc_pkg
`timescale 1ns / 1ps

module tdsc_checker
    import tdsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [11:0]              cfg_wdata,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // finger_index, touch_x, touch_y from bit 0 up
    input  logic [31:0]              s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // touch_state, buttons from bit 0 up
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    output int unsigned              mismatches,
    output int unsigned              outstanding
);

    localparam int TAN_FRAC = TAN_FRAC_BITS_DEF;
    localparam longint TAN_Q =
        longint'((TAN_Q32 + (64'd1 << (31 - TAN_FRAC))) >> (32 - TAN_FRAC));
    localparam longint COT_Q =
        longint'((COT_Q32 + (64'd1 << (31 - TAN_FRAC))) >> (32 - TAN_FRAC));

    typedef struct {
        touch_state_t          state;
        logic [BTN_BITS-1:0]   buttons;
    } dpad_result_t;

    // pad setup as last written
    logic [11:0] cx, cy, rad, dz;
    logic        eight_way, flip_x, flip_y;

    // pad ownership and held buttons
    logic                owned;
    logic [3:0]          owner_id;
    logic [BTN_BITS-1:0] held_buttons;

    dpad_result_t pending_results[$];
    int unsigned  errs;
    int unsigned  result_no;

    // y above the line through the origin with slope k
    function automatic bit above_line(input longint y, input longint x, input longint k);
        return y * (longint'(1) << TAN_FRAC) > x * k;
    endfunction

    function automatic logic [BTN_BITS-1:0] sector_buttons(input longint x, input longint y);
        logic [3:0] side;
        side = '0;
        if (!eight_way) begin
            side[0] = (y > -x);
            side[1] = (y > x);
            case (side[1:0])
                2'b00:   return BTN_DOWN;
                2'b01:   return BTN_RIGHT;
                2'b11:   return BTN_UP;
                default: return BTN_LEFT;
            endcase
        end
        side[0] = above_line(y, -x, COT_Q);
        side[1] = above_line(y, -x, TAN_Q);
        side[2] = above_line(y, x, TAN_Q);
        side[3] = above_line(y, x, COT_Q);
        case (side)
            4'b0000: return BTN_DOWN;
            4'b0001: return BTN_DOWN | BTN_RIGHT;
            4'b0011: return BTN_RIGHT;
            4'b0111: return BTN_UP | BTN_RIGHT;
            4'b1111: return BTN_UP;
            4'b1110: return BTN_UP | BTN_LEFT;
            4'b1100: return BTN_LEFT;
            4'b1000: return BTN_DOWN | BTN_LEFT;
            default: return BTN_NONE;
        endcase
    endfunction

    // classify one report and update ownership
    function automatic dpad_result_t predict_report(input logic [3:0] finger,
                                                    input logic [11:0] tx,
                                                    input logic [11:0] ty);
        longint       dx, dy, dist2;
        dpad_result_t r;
        dx = longint'(tx) - longint'(cx);
        dy = longint'(ty) - longint'(cy);
        if (owned && owner_id != finger) begin
            r.state   = TS_OFF;
            r.buttons = held_buttons;
            return r;
        end
        dist2        = dx * dx + dy * dy;
        held_buttons = BTN_NONE;
        if (dist2 > longint'(rad) * longint'(rad)) begin
            owned   = 1'b0;
            r.state = TS_OFF;
        end
        else begin
            owned    = 1'b1;
            owner_id = finger;
            if (dist2 < longint'(dz) * longint'(dz)) begin
                r.state = TS_DEAD;
            end
            else begin
                r.state      = TS_ACTIVE;
                held_buttons = sector_buttons(flip_x ? -dx : dx, flip_y ? -dy : dy);
            end
        end
        r.buttons = held_buttons;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        dpad_result_t want;
        if (!rst_n) begin
            cx           = '0;
            cy           = '0;
            rad          = '0;
            dz           = '0;
            eight_way    = 1'b0;
            flip_x       = 1'b0;
            flip_y       = 1'b0;
            owned        = 1'b0;
            owner_id     = '0;
            held_buttons = BTN_NONE;
            errs         = 0;
            result_no    = 0;
            pending_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_CENTER_X:    cx        = cfg_wdata;
                    CFG_CENTER_Y:    cy        = cfg_wdata;
                    CFG_RADIUS:      rad       = cfg_wdata;
                    CFG_DEAD_ZONE:   dz        = cfg_wdata;
                    CFG_SECTOR_MODE: eight_way = cfg_wdata[0];
                    CFG_FLIP_X:      flip_x    = cfg_wdata[0];
                    CFG_FLIP_Y:      flip_y    = cfg_wdata[0];
                    default: ;
                endcase
            end
            // results leave before new reports enter, so a same-edge echo is caught
            if (m_tvalid && m_tready) begin
                result_no++;
                if (pending_results.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("result %0d: unexpected, got state %0d buttons %b",
                                 result_no, m_tdata[1:0], m_tdata[5:2]);
                end
                else begin
                    want = pending_results.pop_front();
                    if (m_tdata[1:0] != want.state || m_tdata[5:2] != want.buttons) begin
                        errs++;
                        if (errs <= 10)
                            $display("result %0d: state exp %0d got %0d, buttons exp %b got %b",
                                     result_no, want.state, m_tdata[1:0],
                                     want.buttons, m_tdata[5:2]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_report(s_tdata[3:0], s_tdata[15:4],
                                                         s_tdata[27:16]));
            mismatches  <= errs;
            outstanding <= pending_results.size();
        end
    end

endmodule

### bench/tb_touch_dpad_sector_classifier.sv
// top of the touch d-pad sector classifier bench: clock, reset, pad setups,
// touch reports and result back-pressure; checking sits in tdsc_checker
// depends on tdsc_pkg, tdsc_checker and the classifier rtl
`timescale 1ns / 1ps

module tb_touch_dpad_sector_classifier;
    import tdsc_pkg::*;

    // no item on either side for this long means the block is stuck
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_ITEMS  = 167;
    localparam int SETUP_COUNT  = 11;

    typedef struct {
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] r;
        logic [11:0] dz;
        logic        mode;
        logic        fx;
        logic        fy;
    } dpad_setup_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [11:0]              cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    // finger_index [3:0], touch_x [15:4], touch_y [27:16], zeros above
    logic [31:0]              s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    // touch_state [1:0], buttons [5:2], zeros above
    logic [OUT_DATA_BITS-1:0] m_tdata;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned idle_cycles = 0;
    // while this is set the sender adds no pauses and the receiver is ready outside the hold-off
    logic        steady = 1'b0;

    touch_dpad_sector_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tdsc_checker dpad_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // clamp a centre-relative offset onto the touch surface
    function automatic logic [11:0] place(input logic [11:0] c, input int d);
        int v;
        v = int'(c) + d;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    // stop offering and wait until every report has its result
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // one register write per clock, enable held high across the burst
    task automatic put_reg(input cfg_index_t idx, input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_setup(input dpad_setup_t su);
        drain();
        put_reg(CFG_CENTER_X, su.cx);
        put_reg(CFG_CENTER_Y, su.cy);
        put_reg(CFG_RADIUS, su.r);
        put_reg(CFG_DEAD_ZONE, su.dz);
        put_reg(CFG_SECTOR_MODE, 12'(su.mode));
        put_reg(CFG_FLIP_X, 12'(su.fx));
        put_reg(CFG_FLIP_Y, 12'(su.fy));
        cfg_we <= 1'b0;
    endtask

    // offer one touch report, wait for the handshake, then maybe pause
    task automatic offer(input logic [3:0] finger, input logic [11:0] x,
                         input logic [11:0] y);
        s_tdata  <= {4'b0000, y, x, finger};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        // a random pause after about one item in ten, unless steady
        if (!steady && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // result side: random stalls, one long hold-off, ready when steady outside the hold-off
    initial
    begin : receiver
        int unsigned rx_cycles;
        int unsigned hold_left;
        rx_cycles = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            rx_cycles++;
            // long enough for the pipeline to fill and push back on the sender
            if (rx_cycles == 1200)
                hold_left = 400;
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 20);
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles == IDLE_LIMIT) begin
                $display("tb_touch_dpad_sector_classifier: errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        dpad_setup_t setups [SETUP_COUNT];
        logic [3:0]  favorite;
        logic [3:0]  finger;
        int          g;
        int          k;
        int          rr;
        int          dd;
        int          dx;
        int          dy;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_CENTER_X;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        // directed setups and corners of the register space, then random ones
        setups[0]  = '{12'd2048, 12'd2048, 12'd1000, 12'd100,  1'b1, 1'b0, 1'b0};
        setups[1]  = '{12'd2048, 12'd2048, 12'd1000, 12'd0,    1'b0, 1'b0, 1'b0};
        setups[2]  = '{12'd2048, 12'd2048, 12'd600,  12'd100,  1'b0, 1'b0, 1'b0};
        setups[3]  = '{12'd2048, 12'd2048, 12'd600,  12'd100,  1'b1, 1'b0, 1'b0};
        setups[4]  = '{12'd0,    12'd0,    12'd4095, 12'd0,    1'b1, 1'b1, 1'b0};
        // dead zone equal to radius: only the rim is active
        setups[5]  = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0, 1'b1};
        setups[6]  = '{12'd1000, 12'd3000, 12'd50,   12'd10,   1'b1, 1'b1, 1'b1};
        // zero radius: only the exact centre lands on the pad
        setups[7]  = '{12'd3000, 12'd500,  12'd0,    12'd0,    1'b0, 1'b1, 1'b1};
        setups[8]  = '{12'd2048, 12'd2048, 12'd2000, 12'd300,  1'b1, 1'b0, 1'b1};
        for (int p = 9; p < SETUP_COUNT; p++) begin
            setups[p].cx   = 12'($urandom_range(4095));
            setups[p].cy   = 12'($urandom_range(4095));
            setups[p].r    = 12'($urandom_range(1, 1500));
            setups[p].dz   = 12'($urandom_range(0, setups[p].r));
            setups[p].mode = 1'($urandom_range(1));
            setups[p].fx   = 1'($urandom_range(1));
            setups[p].fy   = 1'($urandom_range(1));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // eight sectors, ownership handoff, dead zone, rim and off-pad
        load_setup(setups[0]);
        offer(4'd3, 12'd2548, 12'd2048);
        offer(4'd5, 12'd2048, 12'd2048);  // other finger while owned
        offer(4'd3, 12'd2048, 12'd2548);
        offer(4'd3, 12'd1548, 12'd2548);
        offer(4'd3, 12'd1548, 12'd2048);
        offer(4'd3, 12'd1548, 12'd1548);
        offer(4'd3, 12'd2048, 12'd1548);
        offer(4'd3, 12'd2548, 12'd1548);
        offer(4'd3, 12'd2548, 12'd2548);
        offer(4'd3, 12'd2058, 12'd2048);  // dead zone
        offer(4'd3, 12'd3048, 12'd2048);  // exactly on the rim
        offer(4'd3, 12'd3049, 12'd2048);  // just outside, releases the pad
        offer(4'd5, 12'd2048, 12'd2048);  // new owner in the dead zone
        offer(4'd15, 12'd0, 12'd0);
        offer(4'd5, 12'd4095, 12'd4095);
        offer(4'd0, 12'd0, 12'd0);
        offer(4'd15, 12'd4095, 12'd0);

        // four sectors: centre with no dead zone, then diagonal ties
        load_setup(setups[1]);
        offer(4'd6, 12'd2048, 12'd2048);
        offer(4'd6, 12'd2348, 12'd2348);
        offer(4'd6, 12'd1748, 12'd2348);
        offer(4'd6, 12'd1748, 12'd1748);
        offer(4'd6, 12'd2348, 12'd1748);

        g        = 0;
        favorite = 4'd9;
        for (int p = 2; p < SETUP_COUNT; p++) begin
            load_setup(setups[p]);
            rr = int'(setups[p].r);
            dd = int'(setups[p].dz);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // mostly one finger holding the pad, others cutting in
                if ($urandom_range(99) < 5)
                    favorite = 4'($urandom_range(15));
                finger = ($urandom_range(99) < 75) ? favorite : 4'($urandom_range(15));
                k = $urandom_range(99);
                if (k < 45) begin
                    dx = int'($urandom_range(0, 2 * rr)) - rr;
                    dy = int'($urandom_range(0, 2 * rr)) - rr;
                end
                else if (k < 60) begin
                    dx = int'($urandom_range(0, 2 * dd)) - dd;
                    dy = int'($urandom_range(0, 2 * dd)) - dd;
                end
                else if (k < 70) begin
                    // on the rim, on an axis or near a diagonal
                    if ($urandom_range(1)) begin
                        dx = $urandom_range(1) ? rr : -rr;
                        dy = 0;
                        if ($urandom_range(1)) begin
                            dy = dx;
                            dx = 0;
                        end
                    end
                    else begin
                        dx = ($urandom_range(1) ? 1 : -1) * (rr * 7071 / 10000);
                        dy = ($urandom_range(1) ? 1 : -1) * (rr * 7071 / 10000)
                             + int'($urandom_range(0, 2)) - 1;
                    end
                end
                else if (k < 80) begin
                    dx = ($urandom_range(1) ? 1 : -1) * (rr + int'($urandom_range(1, 20)));
                    dy = int'($urandom_range(0, 2 * rr)) - rr;
                end
                else begin
                    dx = int'($urandom_range(4095)) - int'(setups[p].cx);
                    dy = int'($urandom_range(4095)) - int'(setups[p].cy);
                end
                steady <= (g >= 700 && g < 1000);
                offer(finger, place(setups[p].cx, dx), place(setups[p].cy, dy));
                g++;
            end
        end

        drain();
        steady <= 1'b0;
        // wait on to catch any result beyond the last one
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_touch_dpad_sector_classifier: clean");
        else
            $display("tb_touch_dpad_sector_classifier: errors");
        $finish;
    end

endmodule
